@@ sv/send_page_pool_policy_unit_assert.svh @@
// ----------------------------------------------------------------------------
// send page pool policy unit assertion macros
// concurrent checks clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef SEND_PAGE_POOL_POLICY_UNIT_ASSERT_SVH
`define SEND_PAGE_POOL_POLICY_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SPP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("send page pool policy unit check failed");
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("send page pool policy unit check failed");
`else
`define SPP_ASSERT(lbl, prop)
`define SPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// shared constants, types and helpers of the send page pool policy unit
// ----------------------------------------------------------------------------
package spp_pkg;

	localparam int PAGES        = 4;
	localparam int HEADER_BYTES = 16;
	localparam int PAGE_W       = (PAGES > 1) ? $clog2(PAGES) : 1;

	localparam int START_W      = 4;
	localparam int BYTES_W      = 24;
	localparam int TIMEOUT_W    = 16;
	localparam int TIME_W       = 32;
	localparam int IDX_OUT_W    = 4;
	localparam int RECORDS_W    = 20;
	localparam int NEED_W       = BYTES_W + 1;
	localparam int REG_IDX_W    = 1;
	localparam int WDATA_W      = BYTES_W;

	localparam logic [RECORDS_W-1:0] RECORDS_MAX       = {RECORDS_W{1'b1}};
	localparam logic [BYTES_W-1:0]   PAGE_BYTES_RST    = 24'd65536;
	localparam logic [TIMEOUT_W-1:0] FLUSH_TIMEOUT_RST = 16'd5;

	localparam logic [REG_IDX_W-1:0] REG_PAGE_BYTES    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FLUSH_TIMEOUT = 1'b1;

	localparam logic ACT_PUSH    = 1'b0;
	localparam logic ACT_SWITCH  = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef logic [PAGE_W-1:0] page_idx_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} ctrl_sts_t;

	// start page folded into the page range
	function automatic page_idx_t start_mod(input logic [START_W-1:0] s);
		page_idx_t r;
		r = '0;
		for (int i = 0; i < (1 << START_W); i++) begin
			if (s == START_W'(i))
				r = PAGE_W'(i % PAGES);
		end
		return r;
	endfunction

endpackage

@@ sv/spp_if.sv @@
// ----------------------------------------------------------------------------
// spp_if
// request, response and configuration channels of the send page pool unit
// ----------------------------------------------------------------------------
interface spp_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [spp_pkg::START_W-1:0]    start_page;
	logic [spp_pkg::BYTES_W-1:0]    record_length;
	logic [spp_pkg::TIME_W-1:0]     now;

	modport source (output valid, action, start_page, record_length, now, input ready);
	modport sink   (input valid, action, start_page, record_length, now, output ready);
endinterface

interface spp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           status;
	logic [spp_pkg::IDX_OUT_W-1:0]  page_index;
	logic [spp_pkg::BYTES_W-1:0]    byte_offset;
	logic [spp_pkg::RECORDS_W-1:0]  record_total;

	modport source (output valid, status, page_index, byte_offset, record_total, input ready);
	modport sink   (input valid, status, page_index, byte_offset, record_total, output ready);
endinterface

interface spp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [spp_pkg::REG_IDX_W-1:0]  reg_index;
	logic [spp_pkg::WDATA_W-1:0]    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ sv/spp_ctrl.sv @@
// ----------------------------------------------------------------------------
// spp_ctrl
// sequencer: accepts an item, runs the clear and scan steps, owns rsp valid
// ----------------------------------------------------------------------------
module spp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_action,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output spp_pkg::ctrl_cmd_t  cmd,
	input  spp_pkg::ctrl_sts_t  sts
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_action == spp_pkg::ACT_SWITCH) ? ST_CLEAR : ST_SCAN;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.hit || sts.last) begin
					if (out_free) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ sv/spp_dp.sv @@
// ----------------------------------------------------------------------------
// spp_dp
// page table, configuration registers, one-page-per-cycle test, result register
// ----------------------------------------------------------------------------
module spp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spp_pkg::ctrl_cmd_t                cmd,
	output spp_pkg::ctrl_sts_t                sts,
	input  logic                              req_action,
	input  logic [spp_pkg::START_W-1:0]       req_start_page,
	input  logic [spp_pkg::BYTES_W-1:0]       req_record_length,
	input  logic [spp_pkg::TIME_W-1:0]        req_now,
	input  logic                              cfg_we,
	input  logic [spp_pkg::REG_IDX_W-1:0]     cfg_reg_index,
	input  logic [spp_pkg::WDATA_W-1:0]       cfg_wdata,
	output logic                              rsp_status,
	output logic [spp_pkg::IDX_OUT_W-1:0]     rsp_page_index,
	output logic [spp_pkg::BYTES_W-1:0]       rsp_byte_offset,
	output logic [spp_pkg::RECORDS_W-1:0]     rsp_record_total
);

	localparam int P = spp_pkg::PAGES;

	logic [P-1:0]                    sending_q;
	logic [spp_pkg::BYTES_W-1:0]     fill_q    [P];
	logic [spp_pkg::RECORDS_W-1:0]   records_q [P];
	logic [spp_pkg::TIME_W-1:0]      stamp_q   [P];

	logic [spp_pkg::BYTES_W-1:0]     page_bytes_q;
	logic [spp_pkg::TIMEOUT_W-1:0]   timeout_q;

	logic                            is_switch_q;
	logic [spp_pkg::BYTES_W-1:0]     len_q;
	logic [spp_pkg::TIME_W-1:0]      now_q;
	spp_pkg::page_idx_t              idx_q;
	spp_pkg::page_idx_t              count_q;

	logic                            status_q;
	logic [spp_pkg::IDX_OUT_W-1:0]   page_index_q;
	logic [spp_pkg::BYTES_W-1:0]     byte_offset_q;
	logic [spp_pkg::RECORDS_W-1:0]   record_total_q;

	logic                            cur_sending;
	logic [spp_pkg::BYTES_W-1:0]     cur_fill;
	logic [spp_pkg::RECORDS_W-1:0]   cur_records;
	logic [spp_pkg::TIME_W-1:0]      cur_stamp;
	logic [spp_pkg::BYTES_W-1:0]     room;
	logic [spp_pkg::NEED_W-1:0]      need;
	logic [spp_pkg::NEED_W-1:0]      fill_sum;
	logic [spp_pkg::TIME_W:0]        stale_at;
	logic                            push_fit;
	logic                            half;
	logic                            stale;
	logic                            hit;
	logic [spp_pkg::RECORDS_W-1:0]   rec_inc;

	assign cur_sending = sending_q[idx_q];
	assign cur_fill    = fill_q[idx_q];
	assign cur_records = records_q[idx_q];
	assign cur_stamp   = stamp_q[idx_q];

	// free space saturates at zero when the capacity was lowered
	assign room     = (cur_fill >= page_bytes_q) ? '0 : page_bytes_q - cur_fill;
	assign need     = spp_pkg::NEED_W'(spp_pkg::HEADER_BYTES) + {1'b0, len_q};
	assign push_fit = !cur_sending && ({1'b0, room} >= need);
	assign fill_sum = {1'b0, cur_fill} + need;

	// idle >= timeout, with a clock going back counting as zero idle
	assign stale_at = {1'b0, cur_stamp} + (spp_pkg::TIME_W + 1)'(timeout_q);
	assign half     = cur_fill > (page_bytes_q >> 1);
	assign stale    = (cur_fill != '0) &&
	                  ((timeout_q == '0) || ({1'b0, now_q} >= stale_at));

	assign hit      = is_switch_q ? (half || stale) : push_fit;
	assign rec_inc  = (cur_records == spp_pkg::RECORDS_MAX) ? cur_records
	                                                         : cur_records + 1'b1;

	assign sts.hit  = hit;
	assign sts.last = (count_q == spp_pkg::PAGE_W'(P - 1));

	assign rsp_status       = status_q;
	assign rsp_page_index   = page_index_q;
	assign rsp_byte_offset  = byte_offset_q;
	assign rsp_record_total = record_total_q;

	// configuration and page table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= spp_pkg::PAGE_BYTES_RST;
			timeout_q    <= spp_pkg::FLUSH_TIMEOUT_RST;
			sending_q    <= '0;
			for (int i = 0; i < P; i++) begin
				fill_q[i]    <= '0;
				records_q[i] <= '0;
				stamp_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_index)
					spp_pkg::REG_PAGE_BYTES:    page_bytes_q <= cfg_wdata;
					spp_pkg::REG_FLUSH_TIMEOUT: timeout_q    <= cfg_wdata[spp_pkg::TIMEOUT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				for (int i = 0; i < P; i++) begin
					if (sending_q[i]) begin
						fill_q[i]    <= '0;
						records_q[i] <= '0;
						stamp_q[i]   <= now_q;
						sending_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.commit && hit) begin
				if (is_switch_q) begin
					sending_q[idx_q] <= 1'b1;
				end else begin
					fill_q[idx_q]    <= fill_sum[spp_pkg::BYTES_W-1:0];
					records_q[idx_q] <= rec_inc;
				end
			end
		end
	end

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			idx_q   <= (req_action == spp_pkg::ACT_SWITCH) ? '0
			                                               : spp_pkg::start_mod(req_start_page);
			count_q <= '0;
		end else if (cmd.step) begin
			idx_q   <= (idx_q == spp_pkg::PAGE_W'(P - 1)) ? '0 : idx_q + 1'b1;
			count_q <= count_q + 1'b1;
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_switch_q <= (req_action == spp_pkg::ACT_SWITCH);
			len_q       <= req_record_length;
			now_q       <= req_now;
		end
		if (cmd.commit) begin
			if (hit) begin
				status_q       <= spp_pkg::STATUS_OK;
				page_index_q   <= spp_pkg::IDX_OUT_W'(idx_q);
				byte_offset_q  <= cur_fill;
				record_total_q <= is_switch_q ? cur_records : rec_inc;
			end else begin
				status_q       <= spp_pkg::STATUS_FAIL;
				page_index_q   <= '0;
				byte_offset_q  <= '0;
				record_total_q <= '0;
			end
		end
	end

endmodule

@@ sv/send_page_pool_policy_unit.sv @@
// ----------------------------------------------------------------------------
// send_page_pool_policy_unit
// Keeps PAGES send pages and answers push and switch requests.
//
// req carries one item: action (push or switch), start_page, record_length
// and now. Each item yields exactly one item on rsp: status, page_index,
// byte_offset and record_total. cfg writes page_bytes (index 0) and
// flush_timeout (index 1); it is always ready. The user must use cfg only
// while idle; the block itself does not enforce this. Timing: req is
// accepted only while idle. A push then tests one page per cycle from
// start_page, holding at its final page while rsp is stalled, and registers
// the result at the hit or the last page; a switch first returns sending
// pages to writable and then tests one page per cycle from page 0 likewise.
// A new req is not taken until the current item has registered its result.
// While rsp is stalled the result register holds; req is still taken, and the
// next item waits at its final step until the register frees up.
// Reset: all pages writable, empty, stamp 0; page_bytes 65536, timeout 5.
// ----------------------------------------------------------------------------
`include "send_page_pool_policy_unit_assert.svh"

module send_page_pool_policy_unit (
	input  logic         clk,
	input  logic         arst_n,
	spp_req_if.sink      req,
	spp_rsp_if.source    rsp,
	spp_cfg_if.sink      cfg
);

	spp_pkg::ctrl_cmd_t cmd;
	spp_pkg::ctrl_sts_t sts;

	assign cfg.ready = 1'b1;

	spp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	spp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_action        (req.action),
		.req_start_page    (req.start_page),
		.req_record_length (req.record_length),
		.req_now           (req.now),
		.cfg_we            (cfg.valid && cfg.ready),
		.cfg_reg_index     (cfg.reg_index),
		.cfg_wdata         (cfg.wdata),
		.rsp_status        (rsp.status),
		.rsp_page_index    (rsp.page_index),
		.rsp_byte_offset   (rsp.byte_offset),
		.rsp_record_total  (rsp.record_total)
	);

	`SPP_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	`SPP_ASSERT(a_commit_needs_slot, cmd.commit |-> (!rsp.valid || rsp.ready))
	`SPP_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.clear, cmd.step, cmd.commit}))
	`SPP_ASSERT(a_fail_zero, (rsp.valid && rsp.status == spp_pkg::STATUS_FAIL) |-> (rsp.page_index == '0 && rsp.byte_offset == '0 && rsp.record_total == '0))

endmodule
